@@ rtl/dec_pkg.sv @@
// Shared types and codes for the group-commit notifier.
// Word layouts of the request and response streams, operation,
// error and state codes. No dependencies.
package dec_pkg;

   localparam logic [1:0] OP_STORE  = 2'd0;
   localparam logic [1:0] OP_LOGGER = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   localparam int TS_W  = 48;
   localparam int SUM_W = 58;
   localparam int EP_W  = 32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MIN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // last member sits in the lowest bits
   typedef struct packed {
      logic [3:0]       pad;
      logic             quit;
      logic [TS_W-1:0]  now_time;
      logic [TS_W-1:0]  mid_time;
      logic [TS_W-1:0]  tx_start;
      logic [2:0]       logger_index;
      logic [EP_W-1:0]  epoch;
   } req_word_type;

   typedef struct packed {
      logic             pad;
      logic [1:0]       error;
      logic [4:0]       buckets_released;
      logic [EP_W-1:0]  epoch_lag_sum;
      logic [TS_W-1:0]  peak_latency;
      logic [TS_W-1:0]  least_latency;
      logic [SUM_W-1:0] notify_latency_sum;
      logic [SUM_W-1:0] latency_sum;
      logic [10:0]      notified_count;
      logic             durable_advanced;
      logic [EP_W-1:0]  min_durable;
   } rsp_word_type;

endpackage

@@ rtl/dec_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module dec_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/durable_epoch_commit_notifier.sv @@
// Group-commit notifier: per-epoch record ring in dec_ram, logger epochs,
// flush drain with latency statistics. Uses dec_pkg and dec_ram.
// Store, logger update and unknown words give a registered response in the
// cycle after acceptance; these can be accepted every cycle while the
// response is taken. Flush: walks logger_count logger epochs (clamped to
// 1..MAX_LOGGERS) for the minimum, then drains buckets (one record RAM read
// per cycle), a stop check and output; input is held until then.
// Reset (sync, high): clears logger epochs, durable/front epoch, fill
// counts; record RAM is not cleared (only filled entries are read).
module durable_epoch_commit_notifier #(
   parameter int MAX_LOGGERS  = 8,
   parameter int RING_BUCKETS = 16,
   parameter int BUCKET_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // epoch, logger_index, tx_start, mid_time, now_time, quit, zero pad
   input  dec_pkg::req_word_type        req_tdata,
   // operation
   input  logic [1:0]                   req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // min_durable, durable_advanced, notified_count, latency_sum,
   // notify_latency_sum, least_latency, peak_latency, epoch_lag_sum,
   // buckets_released, error, zero pad
   output dec_pkg::rsp_word_type        rsp_tdata,
   input  logic                         csr_wen,
   input  logic [3:0]                   csr_wdata
);
   import dec_pkg::*;

   localparam int SW   = $clog2(RING_BUCKETS);
   localparam int KW   = $clog2(BUCKET_DEPTH + 1);
   localparam int BW   = $clog2(RING_BUCKETS + 1);
   localparam int AW   = $clog2(RING_BUCKETS * BUCKET_DEPTH);
   localparam int LIW  = (MAX_LOGGERS > 1) ? $clog2(MAX_LOGGERS) : 1;
   localparam int NW   = $clog2(MAX_LOGGERS + 1);
   localparam int DW   = 2 * TS_W;

   state_type          state_ff, state_in;
   logic [3:0]         lcount_ff;
   logic [EP_W-1:0]    lep_ff [MAX_LOGGERS];
   logic [EP_W-1:0]    lep_in [MAX_LOGGERS];
   logic [EP_W-1:0]    gdur_ff, gdur_in;
   logic [EP_W-1:0]    front_ff, front_in;
   logic [SW-1:0]      fslot_ff, fslot_in;
   logic [KW-1:0]      fill_ff [RING_BUCKETS];
   logic [KW-1:0]      fill_in [RING_BUCKETS];

   logic [TS_W-1:0]    now_ff, now_in;
   logic               quit_ff, quit_in;
   logic [EP_W-1:0]    mn_ff, mn_in;
   logic [NW-1:0]      li_ff, li_in;
   logic [NW-1:0]      nlog_ff, nlog_in;
   logic [BW-1:0]      bcnt_ff, bcnt_in;
   logic [KW-1:0]      k_ff, k_in;
   logic               rdv_ff, rdv_in;
   logic               adv_ff, adv_in;
   logic [10:0]        cnt_ff, cnt_in;
   logic [SUM_W-1:0]   lsum_ff, lsum_in;
   logic [SUM_W-1:0]   nsum_ff, nsum_in;
   logic [TS_W-1:0]    lmin_ff, lmin_in;
   logic [TS_W-1:0]    lmax_ff, lmax_in;
   logic [EP_W-1:0]    lag_ff, lag_in;
   logic [4:0]         nb_ff, nb_in;

   rsp_word_type       rsp_ff, rsp_in;
   logic               rspv_ff, rspv_in;

   logic               ram_wen, ram_ren;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [DW-1:0]      ram_rdata;

   logic               accept;
   logic [EP_W-1:0]    ep_off;
   logic               bad_range;
   logic [SW:0]        slot_sum;
   logic [SW-1:0]      slot;
   logic [6:0]         lidx_ext;
   logic [TS_W-1:0]    dt, nt;
   logic [SUM_W:0]     lsum_add, nsum_add;
   logic [EP_W:0]      lag_add;
   logic [3:0]         nreq;
   rsp_word_type       rsp_default;

   dec_ram #(
      .WIDTH(DW),
      .DEPTH(RING_BUCKETS * BUCKET_DEPTH)
   ) u_records (
      .clock  (clock),
      .wr_en  (ram_wen),
      .wr_addr(ram_waddr),
      .wr_data({req_tdata.mid_time, req_tdata.tx_start}),
      .rd_en  (ram_ren),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE) && (!rspv_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rspv_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      rsp_default               = '0;
      rsp_default.least_latency = '1;

      ep_off    = req_tdata.epoch - front_ff;
      bad_range = (req_tdata.epoch < front_ff) || (ep_off >= EP_W'(RING_BUCKETS));
      slot_sum  = (SW+1)'(fslot_ff) + (SW+1)'(ep_off[SW-1:0]);
      slot      = (slot_sum >= (SW+1)'(RING_BUCKETS)) ?
                  SW'(slot_sum - (SW+1)'(RING_BUCKETS)) : slot_sum[SW-1:0];
      lidx_ext  = 7'(req_tdata.logger_index);

      ram_waddr = AW'(slot) * AW'(BUCKET_DEPTH) + AW'(fill_ff[slot]);
      ram_raddr = AW'(fslot_ff) * AW'(BUCKET_DEPTH) + AW'(k_ff);

      nreq = lcount_ff;
      if (nreq == 4'd0) begin
         nreq = 4'd1;
      end
      if (32'(nreq) > MAX_LOGGERS) begin
         nreq = 4'(MAX_LOGGERS);
      end

      dt       = now_ff - ram_rdata[TS_W-1:0];
      nt       = now_ff - ram_rdata[DW-1:TS_W];
      lsum_add = {1'b0, lsum_ff} + (SUM_W+1)'(dt);
      nsum_add = {1'b0, nsum_ff} + (SUM_W+1)'(nt);
      lag_add  = {1'b0, lag_ff} + {1'b0, mn_ff - front_ff};
   end

   always_comb begin
      state_in = state_ff;
      lep_in   = lep_ff;
      gdur_in  = gdur_ff;
      front_in = front_ff;
      fslot_in = fslot_ff;
      fill_in  = fill_ff;
      now_in   = now_ff;
      quit_in  = quit_ff;
      mn_in    = mn_ff;
      li_in    = li_ff;
      nlog_in  = nlog_ff;
      bcnt_in  = bcnt_ff;
      k_in     = k_ff;
      rdv_in   = 1'b0;
      adv_in   = adv_ff;
      cnt_in   = cnt_ff;
      lsum_in  = lsum_ff;
      nsum_in  = nsum_ff;
      lmin_in  = lmin_ff;
      lmax_in  = lmax_ff;
      lag_in   = lag_ff;
      nb_in    = nb_ff;
      rsp_in   = rsp_ff;
      rspv_in  = rspv_ff && !rsp_tready;
      ram_wen  = 1'b0;
      ram_ren  = 1'b0;

      // read data from the previous drain cycle
      if (rdv_ff) begin
         lsum_in = lsum_add[SUM_W] ? '1 : lsum_add[SUM_W-1:0];
         nsum_in = nsum_add[SUM_W] ? '1 : nsum_add[SUM_W-1:0];
         if (dt < lmin_ff) begin
            lmin_in = dt;
         end
         if (dt > lmax_ff) begin
            lmax_in = dt;
         end
         cnt_in = cnt_ff + 11'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_STORE: begin
                     rsp_in  = rsp_default;
                     rspv_in = 1'b1;
                     if (bad_range) begin
                        rsp_in.error = ERR_RANGE;
                     end else if (32'(fill_ff[slot]) >= BUCKET_DEPTH) begin
                        rsp_in.error = ERR_FULL;
                     end else begin
                        ram_wen       = 1'b1;
                        fill_in[slot] = fill_ff[slot] + KW'(1);
                     end
                  end
                  OP_LOGGER: begin
                     rsp_in  = rsp_default;
                     rspv_in = 1'b1;
                     if (32'(lidx_ext) < MAX_LOGGERS) begin
                        lep_in[lidx_ext[LIW-1:0]] = req_tdata.epoch;
                     end
                  end
                  OP_FLUSH: begin
                     now_in   = req_tdata.now_time;
                     quit_in  = req_tdata.quit;
                     mn_in    = lep_ff[0];
                     li_in    = NW'(1);
                     nlog_in  = NW'(nreq);
                     adv_in   = 1'b0;
                     cnt_in   = '0;
                     lsum_in  = '0;
                     nsum_in  = '0;
                     lmin_in  = '1;
                     lmax_in  = '0;
                     lag_in   = '0;
                     nb_in    = '0;
                     state_in = ST_MIN;
                  end
                  default: begin
                     rsp_in  = rsp_default;
                     rspv_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MIN: begin
            if (li_ff >= nlog_ff) begin
               if (gdur_ff < mn_ff) begin
                  gdur_in = mn_ff;
                  adv_in  = 1'b1;
               end
               bcnt_in  = '0;
               k_in     = '0;
               state_in = (front_ff <= mn_ff) ? ST_DRAIN : ST_DONE;
            end else begin
               if (lep_ff[li_ff[LIW-1:0]] < mn_ff) begin
                  mn_in = lep_ff[li_ff[LIW-1:0]];
               end
               li_in = li_ff + NW'(1);
            end
         end
         ST_DRAIN: begin
            if ((bcnt_ff == BW'(RING_BUCKETS)) || (!quit_ff && front_ff > mn_ff)) begin
               state_in = ST_DONE;
            end else if (k_ff < fill_ff[fslot_ff]) begin
               ram_ren = 1'b1;
               rdv_in  = 1'b1;
               k_in    = k_ff + KW'(1);
            end else begin
               if (!quit_ff) begin
                  lag_in = lag_add[EP_W] ? '1 : lag_add[EP_W-1:0];
               end
               nb_in             = nb_ff + 5'd1;
               fill_in[fslot_ff] = '0;
               front_in          = front_ff + EP_W'(1);
               fslot_in          = (32'(fslot_ff) == RING_BUCKETS - 1) ?
                                   '0 : fslot_ff + SW'(1);
               bcnt_in           = bcnt_ff + BW'(1);
               k_in              = '0;
            end
         end
         ST_DONE: begin
            rsp_in.pad                = 1'b0;
            rsp_in.error              = ERR_OK;
            rsp_in.buckets_released   = nb_ff;
            rsp_in.epoch_lag_sum      = lag_ff;
            rsp_in.peak_latency       = lmax_ff;
            rsp_in.least_latency      = lmin_ff;
            rsp_in.notify_latency_sum = nsum_ff;
            rsp_in.latency_sum        = lsum_ff;
            rsp_in.notified_count     = cnt_ff;
            rsp_in.durable_advanced   = adv_ff;
            rsp_in.min_durable        = mn_ff;
            rspv_in                   = 1'b1;
            state_in                  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         lcount_ff <= 4'd1;
         gdur_ff   <= '0;
         front_ff  <= '0;
         fslot_ff  <= '0;
         rspv_ff   <= 1'b0;
         rdv_ff    <= 1'b0;
         for (int i = 0; i < MAX_LOGGERS; i++) begin
            lep_ff[i] <= '0;
         end
         for (int i = 0; i < RING_BUCKETS; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            lcount_ff <= csr_wdata;
         end
         gdur_ff  <= gdur_in;
         front_ff <= front_in;
         fslot_ff <= fslot_in;
         rspv_ff  <= rspv_in;
         rdv_ff   <= rdv_in;
         lep_ff   <= lep_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff  <= now_in;
      quit_ff <= quit_in;
      mn_ff   <= mn_in;
      li_ff   <= li_in;
      nlog_ff <= nlog_in;
      bcnt_ff <= bcnt_in;
      k_ff    <= k_in;
      adv_ff  <= adv_in;
      cnt_ff  <= cnt_in;
      lsum_ff <= lsum_in;
      nsum_ff <= nsum_in;
      lmin_ff <= lmin_in;
      lmax_ff <= lmax_in;
      lag_ff  <= lag_in;
      nb_ff   <= nb_in;
      rsp_ff  <= rsp_in;
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");

   a_read_in_drain: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> state_ff == ST_DRAIN)
      else $error("record read data outside drain");

   a_front_slot: assert property (@(posedge clock) disable iff (reset)
      32'(fslot_ff) < RING_BUCKETS)
      else $error("front slot out of ring");

   a_no_store_in_flush: assert property (@(posedge clock) disable iff (reset)
      ram_wen |-> !ram_ren && state_ff == ST_IDLE)
      else $error("record write during drain");
`endif

endmodule
